@@ rtl/core/memory_block_lifetime_table_top_defines.svh @@
// assertion macros for the live memory block table
`ifndef MEMORY_BLOCK_LIFETIME_TABLE_TOP_DEFINES_SVH
`define MEMORY_BLOCK_LIFETIME_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked on clk outside reset
`define MBLT_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked on clk outside reset
`define MBLT_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/core/mblt_pkg.sv @@
// shared types and codes of the live memory block table
`default_nettype none

package mblt_pkg;

  localparam int unsigned ID_W = 32;

  // operation codes
  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_END   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERLAP   = 3'd1;
  localparam logic [2:0] ST_NO_BLOCK  = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_ALIVE = 3'd4;
  localparam logic [2:0] ST_MISMATCH  = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_blocked;
  } dp_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/mblt_ctrl.sv @@
// sequencing state machine of the live memory block table
`default_nettype none

module mblt_ctrl
  import mblt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } state_t;

  state_t state;

  // commands decoded from state
  always_comb begin
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.scan   = (state == S_SCAN);
    cmd.commit = (state == S_COMMIT) && !stat.out_blocked;
  end

  // state and stall register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_stall <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_SCAN;
            in_stall <= 1'b1;
          end
        end
        S_SCAN: begin
          if (stat.scan_last) state <= S_DRAIN;
        end
        S_DRAIN: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (!stat.out_blocked) begin
            state    <= S_IDLE;
            in_stall <= 1'b0;
          end
        end
        default: begin
          state    <= S_IDLE;
          in_stall <= 1'b0;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mblt_dpath.sv @@
// table storage, entry compare and result register of the live memory block table
`default_nettype none

module mblt_dpath
  import mblt_pkg::*;
#(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned ADDR_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctl_cmd_t    cmd,
  output dp_stat_t         stat,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] address,
  input  wire logic [31:0] block_size,
  input  wire logic [31:0] expected_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             alive,
  output logic [ID_W-1:0]  lifetime_id,
  output logic [2:0]       status
);

  localparam int unsigned IDXW = $clog2(ENTRIES);

  // table storage
  logic [ADDR_BITS-1:0] mem_base [ENTRIES];
  logic [ADDR_BITS-1:0] mem_len  [ENTRIES];
  logic [ID_W-1:0]      mem_id   [ENTRIES];
  logic [ENTRIES-1:0]   entry_valid;
  logic [ID_W-1:0]      next_id;

  // latched transaction
  logic [1:0]           cur_op;
  logic [ADDR_BITS-1:0] cur_addr;
  logic [ADDR_BITS-1:0] cur_size;
  logic [ID_W-1:0]      cur_expect;

  // scan pipeline
  logic [IDXW-1:0]      rd_idx;
  logic [IDXW-1:0]      cmp_idx;
  logic                 cmp_pend;
  logic [ADDR_BITS-1:0] rd_base;
  logic [ADDR_BITS-1:0] rd_len;
  logic [ID_W-1:0]      rd_id;

  // scan results
  logic                 collide;
  logic                 found;
  logic [ID_W-1:0]      found_id;
  logic                 end_hit;
  logic [IDXW-1:0]      end_idx;
  logic                 free_hit;
  logic [IDXW-1:0]      free_idx;

  logic [ADDR_BITS+31:0] addr_ext;
  logic [ADDR_BITS+31:0] size_ext;
  logic                  ent_v;
  logic                  hit_col;
  logic                  hit_cont;
  logic                  hit_end;
  logic                  wr_en;
  logic                  clr_en;
  logic                  res_alive;
  logic [ID_W-1:0]       res_id;
  logic [2:0]            res_status;

  // inputs taken modulo the address space
  assign addr_ext = {{ADDR_BITS{1'b0}}, address};
  assign size_ext = {{ADDR_BITS{1'b0}}, block_size};

  assign stat.scan_last   = (rd_idx == IDXW'(ENTRIES - 1));
  assign stat.out_blocked = out_valid && out_stall;

  // per-entry compare, no wrap on range ends
  always_comb begin
    ent_v    = entry_valid[cmp_idx];
    hit_col  = ent_v && ((rd_base == cur_addr) ||
               ((rd_base > cur_addr) && (cur_size > (rd_base - cur_addr))) ||
               ((rd_base < cur_addr) && (rd_len > (cur_addr - rd_base))));
    hit_cont = ent_v && (cur_addr >= rd_base) && ((cur_addr - rd_base) < rd_len);
    hit_end  = ent_v && (rd_base == cur_addr);
  end

  // result of the finished scan
  always_comb begin
    res_alive  = 1'b0;
    res_id     = '0;
    res_status = ST_OK;
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    case (cur_op)
      OP_START: begin
        if (collide) begin
          res_status = ST_OVERLAP;
        end else if (!free_hit) begin
          res_status = ST_FULL;
        end else begin
          res_id = next_id;
          wr_en  = 1'b1;
        end
      end
      OP_END: begin
        if (end_hit) clr_en = 1'b1;
        else res_status = ST_NO_BLOCK;
      end
      OP_QUERY: begin
        res_alive = found;
        res_id    = found_id;
      end
      OP_CHECK: begin
        res_alive = found;
        res_id    = found_id;
        if (!found) res_status = ST_NOT_ALIVE;
        else if (found_id != cur_expect) res_status = ST_MISMATCH;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  // table memory: one read a scan cycle, one write at commit
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_base <= mem_base[rd_idx];
      rd_len  <= mem_len[rd_idx];
      rd_id   <= mem_id[rd_idx];
    end
    if (cmd.commit && wr_en) begin
      mem_base[free_idx] <= cur_addr;
      mem_len[free_idx]  <= cur_size;
      mem_id[free_idx]   <= next_id;
    end
  end

  // valid bits, id counter and scan control
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      next_id     <= '0;
      cmp_pend    <= 1'b0;
      rd_idx      <= '0;
    end else begin
      cmp_pend <= cmd.scan;
      if (cmd.load) rd_idx <= '0;
      else if (cmd.scan) rd_idx <= rd_idx + 1'b1;
      if (cmd.commit && wr_en) begin
        entry_valid[free_idx] <= 1'b1;
        next_id               <= next_id + 1'b1;
      end
      if (cmd.commit && clr_en) entry_valid[end_idx] <= 1'b0;
    end
  end

  // transaction latch and scan accumulation
  always_ff @(posedge clk) begin
    if (cmd.scan) cmp_idx <= rd_idx;
    if (cmd.load) begin
      cur_op     <= opcode;
      cur_addr   <= addr_ext[ADDR_BITS-1:0];
      cur_size   <= size_ext[ADDR_BITS-1:0];
      cur_expect <= expected_id;
      collide    <= 1'b0;
      found      <= 1'b0;
      found_id   <= '0;
      end_hit    <= 1'b0;
      end_idx    <= '0;
      free_hit   <= 1'b0;
      free_idx   <= '0;
    end else if (cmp_pend) begin
      if (hit_col) collide <= 1'b1;
      if (hit_cont && !found) begin
        found    <= 1'b1;
        found_id <= rd_id;
      end
      if (hit_end && !end_hit) begin
        end_hit <= 1'b1;
        end_idx <= cmp_idx;
      end
      if (!ent_v && !free_hit) begin
        free_hit <= 1'b1;
        free_idx <= cmp_idx;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      alive       <= res_alive;
      lifetime_id <= res_id;
      status      <= res_status;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/memory_block_lifetime_table_top.sv @@
// top level of the live memory block table
//
//   channel | direction | handshake           | fields
//   in      | input     | in_valid / in_stall   | opcode, address, block_size, expected_id
//   out     | output    | out_valid / out_stall | alive, lifetime_id, status
//
// during a transaction the table entries are read one per cycle
// through the single read port of the table memory, then compared, and the result is committed
// the next transaction is taken once the previous result sits in the output register
// a stalled output holds the commit of the following transaction until it drains
// rst is synchronous; it clears all valid bits and the id counter at once
`default_nettype none

module memory_block_lifetime_table_top
  import mblt_pkg::*;
#(
  parameter int unsigned ENTRIES   = 64,
  parameter int unsigned ADDR_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] address,
  input  wire logic [31:0] block_size,
  input  wire logic [31:0] expected_id,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             alive,
  output logic [31:0]      lifetime_id,
  output logic [2:0]       status
);

  `include "memory_block_lifetime_table_top_defines.svh"

  ctl_cmd_t cmd;
  dp_stat_t stat;

  // sequencer
  mblt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table and compare datapath
  mblt_dpath #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (opcode),
    .address     (address),
    .block_size  (block_size),
    .expected_id (expected_id),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .alive       (alive),
    .lifetime_id (lifetime_id),
    .status      (status)
  );

  // checks
  `MBLT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "not busy after accept")
  `MBLT_ASSERT_NOW(a_result_from_busy, $rose(out_valid), $past(in_stall), "result without transaction")
  `MBLT_ASSERT_NOW(a_commit_not_blocked, cmd.commit, !stat.out_blocked, "commit into full output")
  `MBLT_ASSERT_NOW(a_status_range, out_valid, status <= ST_MISMATCH, "status code out of range")

endmodule

`default_nettype wire
